/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

/* rtl/bofms_pkg.sv */
// ---------------------------------------------------------------------------
// bofms_pkg
// Shared types and constants of the bucketed message store.
// ---------------------------------------------------------------------------
package bofms_pkg;

  localparam int unsigned PRIMARY_SLOTS_DEF = 8;
  localparam int unsigned SHARED_SLOTS_DEF  = 8;
  localparam int unsigned PRIVATE_SLOTS_DEF = 8;
  localparam int unsigned DIRECT_SLOTS_DEF  = 8;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned HDL_W  = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned CC_W   = 4;

  localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = '1;
  localparam logic [CC_W-1:0]  CC_RESET     = 4'd8;

  // request codes
  localparam logic [1:0] FN_ENQ   = 2'd0;
  localparam logic [1:0] FN_POP   = 2'd1;
  localparam logic [1:0] FN_ALLOC = 2'd2;

  // bucket codes, also the slot order in the store
  localparam logic [1:0] BKT_PRIMARY = 2'd0;
  localparam logic [1:0] BKT_SHARED  = 2'd1;
  localparam logic [1:0] BKT_PRIVATE = 2'd2;
  localparam logic [1:0] BKT_DIRECT  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  // slot store controls
  typedef struct packed {
    logic rd_en;    // scan read of sequence and valid
    logic seq_we;   // write sequence, mark valid
    logic hdl_we;   // write handle
    logic vld_clr;  // free a slot
    logic hrd_en;   // read handle
  } mem_ctl_t;

  // min tracker status
  typedef struct packed {
    logic have;        // at least one valid slot seen
    logic free_found;  // at least one free slot seen
  } min_stat_t;

endpackage

/* rtl/bofms_if.sv */
// ---------------------------------------------------------------------------
// bofms_in_if / bofms_out_if
// Valid/ready item channels of the message store.
// ---------------------------------------------------------------------------
interface bofms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        dest_is_broadcast;
  logic [7:0]  channel_index;
  logic        key_matches_primary;
  logic [31:0] message_handle;

  modport source (output valid, func, dest_is_broadcast, channel_index,
                  key_matches_primary, message_handle, input ready);
  modport sink   (input valid, func, dest_is_broadcast, channel_index,
                  key_matches_primary, message_handle, output ready);
endinterface

interface bofms_out_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [1:0]  bucket_used;
  logic        evicted;
  logic [31:0] sequence_out;
  logic [31:0] handle_out;
  logic [31:0] oldest_sequence;

  modport source (output valid, success, bucket_used, evicted, sequence_out,
                  handle_out, oldest_sequence, input ready);
  modport sink   (input valid, success, bucket_used, evicted, sequence_out,
                  handle_out, oldest_sequence, output ready);
endinterface

/* rtl/bofms_slot_mem.sv */
// ---------------------------------------------------------------------------
// bofms_slot_mem
// Slot sequence and handle memories with per-slot valid bits.
// ---------------------------------------------------------------------------
module bofms_slot_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bofms_pkg::mem_ctl_t        ctl,
  input  logic [IDX_W-1:0]           rd_addr,
  input  logic [IDX_W-1:0]           cm_addr,
  input  logic [bofms_pkg::SEQ_W-1:0] wr_seq,
  input  logic [bofms_pkg::HDL_W-1:0] wr_handle,
  output logic [bofms_pkg::SEQ_W-1:0] rd_seq,
  output logic                       rd_valid,
  output logic [bofms_pkg::HDL_W-1:0] rd_handle
);
  import bofms_pkg::*;

  logic [SEQ_W-1:0] seq_mem [DEPTH];
  logic [HDL_W-1:0] hdl_mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.seq_we) begin
      valid_r[cm_addr] <= 1'b1;
    end else if (ctl.vld_clr) begin
      valid_r[cm_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.seq_we) begin
      seq_mem[cm_addr] <= wr_seq;
    end
    if (ctl.rd_en) begin
      rd_seq   <= seq_mem[rd_addr];
      rd_valid <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hdl_we) begin
      hdl_mem[cm_addr] <= wr_handle;
    end
    if (ctl.hrd_en) begin
      rd_handle <= hdl_mem[cm_addr];
    end
  end

endmodule

/* rtl/bofms_min_unit.sv */
// ---------------------------------------------------------------------------
// bofms_min_unit
// Shared compare unit: tracks the lowest valid sequence and first free slot.
// ---------------------------------------------------------------------------
module bofms_min_unit #(
  parameter int unsigned IDX_W = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        sample,
  input  logic                        cand_valid,
  input  logic [bofms_pkg::SEQ_W-1:0] cand_seq,
  input  logic [IDX_W-1:0]            cand_idx,
  output bofms_pkg::min_stat_t        stat,
  output logic [bofms_pkg::SEQ_W-1:0] best_seq,
  output logic [IDX_W-1:0]            best_idx,
  output logic [IDX_W-1:0]            free_idx
);
  import bofms_pkg::*;

  logic have_r;
  logic free_found_r;
  logic [SEQ_W-1:0] best_seq_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [IDX_W-1:0] free_idx_r;
  logic take_best;

  // strict less keeps the lowest index on a tie
  assign take_best = cand_valid && (!have_r || (cand_seq < best_seq_r));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      have_r       <= 1'b0;
      free_found_r <= 1'b0;
    end else if (sample) begin
      if (take_best) begin
        have_r <= 1'b1;
      end
      if (!cand_valid && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample && take_best) begin
      best_seq_r <= cand_seq;
      best_idx_r <= cand_idx;
    end
    if (sample && !cand_valid && !free_found_r) begin
      free_idx_r <= cand_idx;
    end
  end

  assign stat.have       = have_r;
  assign stat.free_found = free_found_r;
  assign best_seq        = best_seq_r;
  assign best_idx        = best_idx_r;
  assign free_idx        = free_idx_r;

endmodule

/* rtl/bucketed_oldest_first_message_store.sv */
// ---------------------------------------------------------------------------
// bucketed_oldest_first_message_store
// Per item: enqueue scans the target bucket, commits, then scans all slots;
//   pop scans all slots, commits, then scans all slots again; allocate /
//   empty bucket / unknown scan all slots once. One item at a time; the single
//   compare unit visits one slot per cycle over the slot memory read port.
// Reset (rst_n low, synchronous): all slots free, next sequence 1, channel
//   count 8; the block accepts items right after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bucketed_oldest_first_message_store #(
  parameter int unsigned PRIMARY_SLOTS = bofms_pkg::PRIMARY_SLOTS_DEF,
  parameter int unsigned SHARED_SLOTS  = bofms_pkg::SHARED_SLOTS_DEF,
  parameter int unsigned PRIVATE_SLOTS = bofms_pkg::PRIVATE_SLOTS_DEF,
  parameter int unsigned DIRECT_SLOTS  = bofms_pkg::DIRECT_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bofms_pkg::CC_W-1:0] cfg_wdata,
  bofms_in_if.sink                   in_ch,
  bofms_out_if.source                out_ch
);
  import bofms_pkg::*;

  // Slots lie in bucket order: primary, shared-key, private, direct.
  localparam int unsigned TOTAL        = PRIMARY_SLOTS + SHARED_SLOTS +
                                         PRIVATE_SLOTS + DIRECT_SLOTS;
  localparam int unsigned MEM_DEPTH    = (TOTAL > 0) ? TOTAL : 1;
  localparam int unsigned IDX_W        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned BASE_SHARED  = PRIMARY_SLOTS;
  localparam int unsigned BASE_PRIVATE = PRIMARY_SLOTS + SHARED_SLOTS;
  localparam int unsigned BASE_DIRECT  = PRIMARY_SLOTS + SHARED_SLOTS + PRIVATE_SLOTS;
  localparam bit          HAS_SLOTS    = (TOTAL > 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_DEPTH - 1);

  // Sequencer state
  state_t state_r, state_nxt;
  logic   final_r;      // scan in progress is the closing oldest-entry pass
  logic   pend_r;       // slot read data arrives this cycle
  logic [IDX_W-1:0] addr_r;
  logic [IDX_W-1:0] end_r;
  logic [IDX_W-1:0] idx_d_r;

  // Configuration and sequence counter
  logic [CC_W-1:0]  cc_r;
  logic [SEQ_W-1:0] nseq_r;
  logic [SEQ_W-1:0] nseq_inc;

  // Latched request
  logic [1:0]        func_r;
  logic              bc_r;
  logic [CHAN_W-1:0] chan_r;
  logic              key_r;
  logic [HDL_W-1:0]  hdl_r;

  // Result registers
  logic             success_r;
  logic [1:0]       bucket_r;
  logic             evicted_r;
  logic [SEQ_W-1:0] seq_out_r;
  logic             hsel_r;    // handle comes from the handle memory

  // Decode
  logic [1:0]       bsel;
  int unsigned      bstart;
  int unsigned      bcap;
  logic             do_find;
  logic [1:0]       pop_bkt;

  // Unit connections
  mem_ctl_t         mctl;
  min_stat_t        mstat;
  logic             mu_clear;
  logic [SEQ_W-1:0] rd_seq;
  logic             rd_valid;
  logic [HDL_W-1:0] rd_handle;
  logic [SEQ_W-1:0] best_seq;
  logic [IDX_W-1:0] best_idx;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] cm_addr;
  logic [IDX_W-1:0] enq_tgt;

  // -------------------------------------------------------------------------
  // Sub-units
  // -------------------------------------------------------------------------
  bofms_slot_mem #(
    .DEPTH (MEM_DEPTH),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mctl),
    .rd_addr   (addr_r),
    .cm_addr   (cm_addr),
    .wr_seq    (nseq_r),
    .wr_handle (hdl_r),
    .rd_seq    (rd_seq),
    .rd_valid  (rd_valid),
    .rd_handle (rd_handle)
  );

  bofms_min_unit #(
    .IDX_W (IDX_W)
  ) u_min_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (mu_clear),
    .sample     (pend_r),
    .cand_valid (rd_valid),
    .cand_seq   (rd_seq),
    .cand_idx   (idx_d_r),
    .stat       (mstat),
    .best_seq   (best_seq),
    .best_idx   (best_idx),
    .free_idx   (free_idx)
  );

  // -------------------------------------------------------------------------
  // Request decode
  // -------------------------------------------------------------------------
  // Bucket choice: direct for unicast, primary on channel 0, private at or
  // above the channel count, shared-key on key match, otherwise private.
  always_comb begin
    bsel = BKT_PRIVATE;
    if (!bc_r) begin
      bsel = BKT_DIRECT;
    end else if (chan_r == '0) begin
      bsel = BKT_PRIMARY;
    end else if (chan_r >= {{(CHAN_W-CC_W){1'b0}}, cc_r}) begin
      bsel = BKT_PRIVATE;
    end else if (key_r) begin
      bsel = BKT_SHARED;
    end
  end

  always_comb begin
    case (bsel)
      BKT_PRIMARY: begin
        bstart = 0;
        bcap   = PRIMARY_SLOTS;
      end
      BKT_SHARED: begin
        bstart = BASE_SHARED;
        bcap   = SHARED_SLOTS;
      end
      BKT_PRIVATE: begin
        bstart = BASE_PRIVATE;
        bcap   = PRIVATE_SLOTS;
      end
      default: begin
        bstart = BASE_DIRECT;
        bcap   = DIRECT_SLOTS;
      end
    endcase
  end

  // A first scan is needed for enqueue into a bucket with slots and for pop when the store has slots.
  assign do_find = ((func_r == FN_ENQ) && (bcap != 0)) ||
                   ((func_r == FN_POP) && HAS_SLOTS);

  // Bucket of the popped slot: highest bucket whose base is at or below it.
  always_comb begin
    if (32'(best_idx) >= BASE_DIRECT) begin
      pop_bkt = BKT_DIRECT;
    end else if (32'(best_idx) >= BASE_PRIVATE) begin
      pop_bkt = BKT_PRIVATE;
    end else if (32'(best_idx) >= BASE_SHARED) begin
      pop_bkt = BKT_SHARED;
    end else begin
      pop_bkt = BKT_PRIMARY;
    end
  end

  // Sequence counter wraps past all ones to 1, never 0.
  assign nseq_inc = (nseq_r == SEQ_ALL_ONES) ? SEQ_W'(1) : nseq_r + SEQ_W'(1);

  // Full bucket: the tracker holds the oldest entry, lowest index on a tie.
  assign enq_tgt = mstat.free_found ? free_idx : best_idx;
  assign cm_addr = (func_r == FN_ENQ) ? enq_tgt : best_idx;

  // -------------------------------------------------------------------------
  // Sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (do_find || HAS_SLOTS) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (addr_r == end_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = final_r ? ST_RESULT : ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = ST_SCAN;
      end
      ST_RESULT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer: outputs
  // -------------------------------------------------------------------------
  always_comb begin
    mctl         = '0;
    mu_clear     = 1'b0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_DECODE: begin
        mu_clear = 1'b1;
      end
      ST_SCAN: begin
        mctl.rd_en = 1'b1;
      end
      ST_DRAIN: begin
        mctl = '0;
      end
      ST_COMMIT: begin
        mu_clear = 1'b1;
        if (func_r == FN_ENQ) begin
          mctl.seq_we = 1'b1;
          mctl.hdl_we = 1'b1;
        end else if (mstat.have) begin
          mctl.vld_clr = 1'b1;
          mctl.hrd_en  = 1'b1;
        end
      end
      ST_RESULT: begin
        out_ch.valid = 1'b1;
      end
      default: begin
        mctl = '0;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
      pend_r  <= 1'b0;
      cc_r    <= CC_RESET;
      nseq_r  <= SEQ_W'(1);
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN);
      if (cfg_we) begin
        cc_r <= cfg_wdata;
      end
      case (state_r)
        ST_DECODE: begin
          final_r <= !do_find;
          if (func_r == FN_ALLOC) begin
            nseq_r <= nseq_inc;
          end
        end
        ST_COMMIT: begin
          final_r <= 1'b1;
          if (func_r == FN_ENQ) begin
            nseq_r <= nseq_inc;
          end
        end
        default: begin
          final_r <= final_r;
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Datapath registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    idx_d_r <= addr_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          func_r <= in_ch.func;
          bc_r   <= in_ch.dest_is_broadcast;
          chan_r <= in_ch.channel_index;
          key_r  <= in_ch.key_matches_primary;
          hdl_r  <= in_ch.message_handle;
        end
      end
      ST_DECODE: begin
        // allocate is complete here; other requests keep these defaults unless a commit fills them in
        success_r <= (func_r == FN_ALLOC);
        bucket_r  <= (func_r == FN_ENQ) ? bsel : BKT_PRIMARY;
        evicted_r <= 1'b0;
        seq_out_r <= (func_r == FN_ALLOC) ? nseq_r : '0;
        hsel_r    <= 1'b0;
        if (do_find && (func_r == FN_ENQ)) begin
          addr_r <= IDX_W'(bstart);
          end_r  <= IDX_W'(bstart + bcap - 1);
        end else begin
          addr_r <= '0;
          end_r  <= LAST_IDX;
        end
      end
      ST_SCAN: begin
        if (addr_r != end_r) begin
          addr_r <= addr_r + IDX_W'(1);
        end
      end
      ST_COMMIT: begin
        addr_r <= '0;
        end_r  <= LAST_IDX;
        if (func_r == FN_ENQ) begin
          success_r <= 1'b1;
          seq_out_r <= nseq_r;
          evicted_r <= !mstat.free_found;
        end else if (mstat.have) begin
          success_r <= 1'b1;
          bucket_r  <= pop_bkt;
          seq_out_r <= best_seq;
          hsel_r    <= 1'b1;
        end
      end
      default: begin
        addr_r <= addr_r;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Result channel
  // -------------------------------------------------------------------------
  assign out_ch.success         = success_r;
  assign out_ch.bucket_used     = bucket_r;
  assign out_ch.evicted         = evicted_r;
  assign out_ch.sequence_out    = seq_out_r;
  assign out_ch.handle_out      = hsel_r ? rd_handle : '0;
  assign out_ch.oldest_sequence = mstat.have ? best_seq : SEQ_ALL_ONES;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_NEVER(a_nseq_nonzero, clk, rst_n, nseq_r == '0, "next sequence is zero")
  `ASSERT_CLK(a_enq_has_target, clk, rst_n,
    (state_r == ST_COMMIT && func_r == FN_ENQ) |-> (mstat.free_found || mstat.have),
    "enqueue commit without a target slot")
  `ASSERT_CLK(a_scan_in_range, clk, rst_n,
    (state_r == ST_SCAN) |-> (addr_r <= end_r && end_r <= LAST_IDX),
    "scan address beyond range")
  `ASSERT_CLK(a_evict_success, clk, rst_n,
    (out_ch.valid && out_ch.evicted) |-> (out_ch.success && func_r == FN_ENQ),
    "eviction flagged on a failed or non-enqueue item")

endmodule
